/* hw/rtl/nea_pkg.sv */
// Shared types and constants for the neighbour energy average block.
// No dependencies.
package nea_pkg;

    // Action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Field widths fixed by the interface
    localparam int ID_W    = 24;
    localparam int POS_W   = 32;
    localparam int EN_W    = 32;
    localparam int QIDX_W  = 12;
    localparam int CNT_O_W = 13;
    localparam int RAD_W   = 22;
    localparam int WORD_W  = ID_W + 3 * POS_W + EN_W;

    // Register index of the cutoff radius
    localparam logic [2:0] REG_CUTOFF = 3'd0;
    localparam logic [RAD_W-1:0] CUTOFF_RESET = 22'd40960;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic q_capture;
        logic q_rd;
        logic q_latch;
        logic sweep;
        logic div_load;
        logic out_query;
        logic out_invalid;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic q_ok;
        logic sweep_last;
        logic pipe_empty;
        logic div_done;
    } t_dp_sts;

endpackage

/* hw/rtl/nea_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module nea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* hw/rtl/nea_ctrl.sv */
// Controller state machine for the neighbour energy average block.
// Depends on nea_pkg.
module nea_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_action,
    input  nea_pkg::t_dp_sts i_sts,
    output nea_pkg::t_dp_cmd o_cmd,
    output logic            o_busy
);
    import nea_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QRD   = 3'd1;
    localparam logic [2:0] S_QLAT  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_CLEAR: o_cmd.clear = 1'b1;
                        ACT_LOAD:  o_cmd.load  = 1'b1;
                        ACT_QUERY: begin
                            if (i_sts.q_ok) begin
                                o_cmd.q_capture = 1'b1;
                                n_state = S_QRD;
                            end else begin
                                o_cmd.out_invalid = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_QRD: begin
                o_cmd.q_rd = 1'b1;
                n_state = S_QLAT;
            end
            S_QLAT: begin
                o_cmd.q_latch = 1'b1;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    o_cmd.div_load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_query = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

/* hw/rtl/nea_dp.sv */
// Datapath: particle store, distance pipeline, accumulators and divider.
// Depends on nea_pkg and nea_ram.
module nea_dp #(
    parameter int MAX_PARTICLES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nea_pkg::t_dp_cmd              i_cmd,
    output nea_pkg::t_dp_sts              o_sts,
    input  logic [nea_pkg::RAD_W-1:0]     i_cutoff,
    input  logic [nea_pkg::ID_W-1:0]      i_particle_id,
    input  logic signed [nea_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [nea_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [nea_pkg::POS_W-1:0] i_pos_z,
    input  logic [nea_pkg::EN_W-1:0]      i_energy,
    input  logic [nea_pkg::QIDX_W-1:0]    i_query_index,
    output logic                          o_result_valid,
    output logic [nea_pkg::ID_W-1:0]      o_result_id,
    output logic [nea_pkg::EN_W-1:0]      o_mean_energy,
    output logic [nea_pkg::CNT_O_W-1:0]   o_neighbour_count,
    output logic                          o_index_invalid
);
    import nea_pkg::*;

    localparam int AW  = $clog2(MAX_PARTICLES);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int SW  = EN_W + CW;
    localparam int DW  = POS_W + 1;
    localparam int SQW = 2 * RAD_W;
    localparam int SSW = SQW + 2;
    localparam int DCW = $clog2(EN_W + 1);

    // Stored count and particle store
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_qaddr;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic              full;

    assign full      = (r_count == CW'(MAX_PARTICLES));
    assign ram_we    = i_cmd.load && !full;
    assign ram_wdata = {i_particle_id, i_pos_x, i_pos_y, i_pos_z, i_energy};
    assign ram_addr  = ram_we ? r_count[AW-1:0] : (i_cmd.q_rd ? r_qaddr : r_idx);

    nea_ram #(.WIDTH(WORD_W), .DEPTH(MAX_PARTICLES)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Unpack read word
    logic [ID_W-1:0]         rd_id;
    logic signed [POS_W-1:0] rd_x, rd_y, rd_z;
    logic [EN_W-1:0]         rd_e;
    assign {rd_id, rd_x, rd_y, rd_z, rd_e} = ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (ram_we) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Query particle and sweep index
    logic [ID_W-1:0]         r_qid;
    logic signed [POS_W-1:0] r_qx, r_qy, r_qz;
    logic [RAD_W-1:0]        r_rad;
    logic [SQW-1:0]          r_rad2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_capture) begin
            r_qaddr <= AW'(i_query_index);
        end
        if (i_cmd.q_latch) begin
            r_qid  <= rd_id;
            r_qx   <= rd_x;
            r_qy   <= rd_y;
            r_qz   <= rd_z;
            r_rad  <= i_cutoff;
            r_rad2 <= SQW'(i_cutoff) * SQW'(i_cutoff);
            r_idx  <= '0;
        end else if (i_cmd.sweep) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    assign o_sts.q_ok       = (32'(i_query_index) < 32'(r_count));
    assign o_sts.sweep_last = (CW'(r_idx) == r_count - 1'b1);

    // Stage valids
    logic r_v0, r_v1, r_v2, r_v3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.sweep;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end
    assign o_sts.pipe_empty = !(r_v0 || r_v1 || r_v2 || r_v3);

    // Stage 1: absolute differences and per-axis exclusion
    logic signed [DW-1:0] dx, dy, dz;
    logic [DW-1:0]        ax, ay, az;
    logic [RAD_W-1:0]     r_ax, r_ay, r_az;
    logic                 r_in1;
    logic [EN_W-1:0]      r_e1, r_e2, r_e3;

    always_comb begin
        dx = DW'(rd_x) - DW'(r_qx);
        dy = DW'(rd_y) - DW'(r_qy);
        dz = DW'(rd_z) - DW'(r_qz);
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
        az = dz[DW-1] ? DW'(-dz) : DW'(dz);
    end

    always_ff @(posedge i_clk) begin
        r_ax  <= ax[RAD_W-1:0];
        r_ay  <= ay[RAD_W-1:0];
        r_az  <= az[RAD_W-1:0];
        r_in1 <= (ax <= DW'(r_rad)) && (ay <= DW'(r_rad)) && (az <= DW'(r_rad));
        r_e1  <= rd_e;
    end

    // Stage 2: squares
    logic [SQW-1:0] r_sx, r_sy, r_sz;
    logic           r_in2;
    always_ff @(posedge i_clk) begin
        r_sx  <= SQW'(r_ax) * SQW'(r_ax);
        r_sy  <= SQW'(r_ay) * SQW'(r_ay);
        r_sz  <= SQW'(r_az) * SQW'(r_az);
        r_in2 <= r_in1;
        r_e2  <= r_e1;
    end

    // Stage 3: sum of squares against squared cutoff
    logic r_hit;
    always_ff @(posedge i_clk) begin
        r_hit <= r_in2 && ((SSW'(r_sx) + SSW'(r_sy) + SSW'(r_sz)) <= SSW'(r_rad2));
        r_e3  <= r_e2;
    end

    // Stage 4: accumulate count and energy
    logic [CW-1:0] r_acc_cnt;
    logic [SW-1:0] r_acc_sum;
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_latch) begin
            r_acc_cnt <= '0;
            r_acc_sum <= '0;
        end else if (r_v3 && r_hit) begin
            r_acc_cnt <= r_acc_cnt + 1'b1;
            r_acc_sum <= r_acc_sum + SW'(r_e3);
        end
    end

    // Restoring divider, one quotient bit a cycle
    logic [CW-1:0]   r_rem;
    logic [EN_W-1:0] r_quo;
    logic [DCW-1:0]  r_dcnt;
    logic [CW:0]     rem_sh;
    logic            rem_ge;

    assign rem_sh = {r_rem, r_quo[EN_W-1]};
    assign rem_ge = (rem_sh >= (CW+1)'(r_acc_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_load) begin
            r_rem  <= r_acc_sum[SW-1:EN_W];
            r_quo  <= r_acc_sum[EN_W-1:0];
            r_dcnt <= DCW'(EN_W);
        end else if (r_dcnt != '0) begin
            r_rem  <= rem_ge ? CW'(rem_sh - (CW+1)'(r_acc_cnt)) : CW'(rem_sh);
            r_quo  <= {r_quo[EN_W-2:0], rem_ge};
            r_dcnt <= r_dcnt - 1'b1;
        end
    end
    assign o_sts.div_done = (r_dcnt == '0);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.out_query || i_cmd.out_invalid;
        end
        if (i_cmd.out_query) begin
            o_result_id       <= r_qid;
            o_mean_energy     <= r_quo;
            o_neighbour_count <= CNT_O_W'(r_acc_cnt);
            o_index_invalid   <= 1'b0;
        end else if (i_cmd.out_invalid) begin
            o_result_id       <= '0;
            o_mean_energy     <= '0;
            o_neighbour_count <= '0;
            o_index_invalid   <= 1'b1;
        end
    end
endmodule

/* hw/rtl/neighbour_energy_average_top.sv */
// Neighbour energy average: clear and load are taken from idle and never raise busy.
// A query holds busy while it reads the queried particle, sweeps the store for the
// distance test at one store read per cycle, empties the four-stage pipeline, runs
// the bit-serial divide and registers the result word; the next word goes in once
// busy falls. An invalid query answers in the cycle after acceptance. Results strobe
// once and cannot be stalled. Synchronous active-low reset empties the store and sets
// the cutoff to CUTOFF_RESET (40960).
// Depends on nea_pkg, nea_ctrl, nea_dp.
module neighbour_energy_average_top #(
    parameter int MAX_PARTICLES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_action,
    input  logic [nea_pkg::ID_W-1:0]         i_particle_id,
    input  logic signed [nea_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [nea_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [nea_pkg::POS_W-1:0] i_pos_z,
    input  logic [nea_pkg::EN_W-1:0]         i_energy,
    input  logic [nea_pkg::QIDX_W-1:0]       i_query_index,
    output logic                             o_result_valid,
    output logic [nea_pkg::ID_W-1:0]         o_result_id,
    output logic [nea_pkg::EN_W-1:0]         o_mean_energy,
    output logic [nea_pkg::CNT_O_W-1:0]      o_neighbour_count,
    output logic                             o_index_invalid,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import nea_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [RAD_W-1:0] r_cutoff;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (psel && penable && pwrite && paddr == REG_CUTOFF) begin
            r_cutoff <= pwdata[RAD_W-1:0];
        end
    end
    assign prdata = (paddr == REG_CUTOFF) ? 32'(r_cutoff) : '0;

    nea_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_action(i_action),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    nea_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cutoff         (r_cutoff),
        .i_particle_id    (i_particle_id),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_energy         (i_energy),
        .i_query_index    (i_query_index),
        .o_result_valid   (o_result_valid),
        .o_result_id      (o_result_id),
        .o_mean_energy    (o_mean_energy),
        .o_neighbour_count(o_neighbour_count),
        .o_index_invalid  (o_index_invalid)
    );
endmodule
